### rtl/sfd_pkg.sv
package sfd_pkg;

   localparam int unsigned FRAME_BYTES = 16;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0]  SYNC_BYTE = 8'hA5;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   localparam logic [1:0] STATUS_GOOD = 2'd0;
   localparam logic [1:0] STATUS_CRC  = 2'd1;
   localparam logic [1:0] STATUS_OWN  = 2'd2;

   // One assembled frame, handed from the front end to the result stage.
   typedef struct packed {
      logic        crc_ok;
      logic [7:0]  frame_type;
      logic [15:0] source_tag;
      logic [15:0] dest_tag;
      logic [15:0] proto_version;
      logic [31:0] argument;
      logic [7:0]  frame_flags;
   } frame_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // CRC-16/CCITT-FALSE update for one byte, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/sfd_front.sv
module sfd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   input  sfd_pkg::queue_status_type q_status,
   output logic                      push,
   output sfd_pkg::frame_rec_type    push_rec
);

   localparam logic [3:0] LAST_POS = 4'(sfd_pkg::FRAME_BYTES - 1);
   localparam logic [3:0] CRC_LO_POS = 4'(sfd_pkg::FRAME_BYTES - 2);

   logic [3:0]  byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff;
   logic [7:0]  type_ff, flags_ff;
   logic [15:0] src_ff, dst_ff, ver_ff;
   logic [31:0] arg_ff;
   logic        take;
   logic        in_frame;

   // Only the closing byte needs room in the queue.
   assign req_stall = q_status.full && (byte_count_ff == LAST_POS);
   assign take      = req_valid && !req_stall;
   assign in_frame  = (byte_count_ff != 4'd0) || (req_rx_byte == sfd_pkg::SYNC_BYTE);

   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      push          = 1'b0;
      if (take && in_frame) begin
         byte_count_in = byte_count_ff + 4'd1;
         if (byte_count_ff == 4'd0) begin
            crc_in = sfd_pkg::crc_byte(sfd_pkg::CRC_INIT, req_rx_byte);
         end else if (byte_count_ff < CRC_LO_POS) begin
            crc_in = sfd_pkg::crc_byte(crc_ff, req_rx_byte);
         end
         if (byte_count_ff == LAST_POS) begin
            push = 1'b1;
         end
      end
   end

   always_comb begin
      push_rec.crc_ok        = ({req_rx_byte, crc_lo_ff} == crc_ff);
      push_rec.frame_type    = type_ff;
      push_rec.source_tag    = src_ff;
      push_rec.dest_tag      = dst_ff;
      push_rec.proto_version = ver_ff;
      push_rec.argument      = arg_ff;
      push_rec.frame_flags   = flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 4'd0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (take && in_frame) begin
         unique case (byte_count_ff)
            4'd1:    type_ff         <= req_rx_byte;
            4'd2:    src_ff[7:0]     <= req_rx_byte;
            4'd3:    src_ff[15:8]    <= req_rx_byte;
            4'd4:    dst_ff[7:0]     <= req_rx_byte;
            4'd5:    dst_ff[15:8]    <= req_rx_byte;
            4'd6:    ver_ff[7:0]     <= req_rx_byte;
            4'd7:    ver_ff[15:8]    <= req_rx_byte;
            4'd8:    arg_ff[7:0]     <= req_rx_byte;
            4'd9:    arg_ff[15:8]    <= req_rx_byte;
            4'd10:   arg_ff[23:16]   <= req_rx_byte;
            4'd11:   arg_ff[31:24]   <= req_rx_byte;
            4'd12:   flags_ff        <= req_rx_byte;
            4'd14:   crc_lo_ff       <= req_rx_byte;
            default: ;
         endcase
      end
   end

endmodule

### rtl/sfd_queue.sv
module sfd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sfd_pkg::frame_rec_type    push_rec,
   input  logic                      pop,
   output sfd_pkg::frame_rec_type    head_rec,
   output sfd_pkg::queue_status_type q_status
);

   localparam int unsigned DEPTH = sfd_pkg::QUEUE_DEPTH;
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sfd_pkg::frame_rec_type entry_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head_rec       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !(push && !pop))
      else $error("frame queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("frame queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("frame queue occupancy out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("frame queue occupancy did not follow a write");
`endif

endmodule

### rtl/sfd_back.sv
module sfd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [15:0]               csr_wr_data,
   input  sfd_pkg::frame_rec_type    head_rec,
   input  sfd_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_frame_status,
   output logic [7:0]                rsp_frame_type,
   output logic [15:0]               rsp_source_tag,
   output logic [15:0]               rsp_dest_tag,
   output logic [15:0]               rsp_proto_version,
   output logic [31:0]               rsp_argument,
   output logic [7:0]                rsp_frame_flags,
   output logic [31:0]               rsp_crc_error_total,
   output logic [31:0]               rsp_good_frame_total
);

   logic [15:0] own_tag_val_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] crc_err_ff, crc_err_in;
   logic [31:0] good_ff, good_in;
   logic [1:0]  status_in;
   logic        is_own;

   assign pop    = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign is_own = (head_rec.source_tag == own_tag_val_ff);

   always_comb begin
      crc_err_in   = crc_err_ff;
      good_in      = good_ff;
      status_in    = sfd_pkg::STATUS_GOOD;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in = 1'b1;
         priority if (!head_rec.crc_ok) begin
            status_in  = sfd_pkg::STATUS_CRC;
            crc_err_in = crc_err_ff + 32'd1;
         end else if (is_own) begin
            status_in = sfd_pkg::STATUS_OWN;
         end else begin
            status_in = sfd_pkg::STATUS_GOOD;
            good_in   = good_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_tag_val_ff <= 16'd0;
         rsp_valid_ff   <= 1'b0;
         crc_err_ff     <= 32'd0;
         good_ff        <= 32'd0;
      end else begin
         if (csr_wr_en) begin
            own_tag_val_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         crc_err_ff   <= crc_err_in;
         good_ff      <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_frame_status     <= status_in;
         rsp_crc_error_total  <= crc_err_in;
         rsp_good_frame_total <= good_in;
         if (head_rec.crc_ok) begin
            rsp_frame_type    <= head_rec.frame_type;
            rsp_source_tag    <= head_rec.source_tag;
            rsp_dest_tag      <= head_rec.dest_tag;
            rsp_proto_version <= head_rec.proto_version;
            rsp_argument      <= head_rec.argument;
            rsp_frame_flags   <= head_rec.frame_flags;
         end else begin
            rsp_frame_type    <= 8'd0;
            rsp_source_tag    <= 16'd0;
            rsp_dest_tag      <= 16'd0;
            rsp_proto_version <= 16'd0;
            rsp_argument      <= 32'd0;
            rsp_frame_flags   <= 8'd0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("result register reloaded while its transaction was stalled");

   a_crc_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !head_rec.crc_ok) |=> (crc_err_ff == $past(crc_err_ff) + 32'd1))
      else $error("CRC error count did not advance on a failed frame");

   a_good_stable: assert property (@(posedge clock) disable iff (reset)
      !pop |=> $stable(good_ff) && $stable(crc_err_ff))
      else $error("frame counters changed without a frame");
`endif

endmodule

### rtl/sync_frame_deframer_crc16.sv
// rsp_valid rises once the frame has left the frame queue and is loaded into the result register.
// Throughput: one received byte per cycle while req_stall is low; at most one result per 16-byte frame.
// The byte input stalls only on a closing byte while the two-entry frame queue is full.
// Reset (synchronous, active high) restarts the sync hunt, empties the frame queue,
// drops any pending result, clears both frame counters and sets the own tag to zero.
module sync_frame_deframer_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_frame_status,
   output logic [7:0]  rsp_frame_type,
   output logic [15:0] rsp_source_tag,
   output logic [15:0] rsp_dest_tag,
   output logic [15:0] rsp_proto_version,
   output logic [31:0] rsp_argument,
   output logic [7:0]  rsp_frame_flags,
   output logic [31:0] rsp_crc_error_total,
   output logic [31:0] rsp_good_frame_total
);

   // The front end hunts for the sync byte, runs the CRC one byte per cycle
   // unless stalled, and latches the header fields at their fixed byte positions.
   // When the sixteenth byte arrives, it compares the trailing little-endian CRC
   // and pushes the whole frame, tagged good or bad, into a short queue.
   sfd_pkg::frame_rec_type    push_rec;
   sfd_pkg::frame_rec_type    head_rec;
   sfd_pkg::queue_status_type q_status;
   logic                      push;
   logic                      pop;

   sfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_rec    (push_rec)
   );

   // The queue decouples byte intake from the result channel, so a stalled
   // result transaction does not hold up the line for a whole frame.
   sfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   // The back end classifies each frame against the own tag, updates the
   // wrapping counters and holds the result transaction in its output register.
   sfd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .head_rec             (head_rec),
      .q_status             (q_status),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_frame_status     (rsp_frame_status),
      .rsp_frame_type       (rsp_frame_type),
      .rsp_source_tag       (rsp_source_tag),
      .rsp_dest_tag         (rsp_dest_tag),
      .rsp_proto_version    (rsp_proto_version),
      .rsp_argument         (rsp_argument),
      .rsp_frame_flags      (rsp_frame_flags),
      .rsp_crc_error_total  (rsp_crc_error_total),
      .rsp_good_frame_total (rsp_good_frame_total)
   );

endmodule

### tb/testbench.sv
module testbench;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 6;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int FRAMES_PER_PHASE = 5;

   // One received frame as it sits on the line, byte 0 first.
   typedef logic [sfd_pkg::FRAME_BYTES-1:0][7:0] frame_image_type;

   // Everything the block reports for one completed frame.
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  ftype;
      logic [15:0] source;
      logic [15:0] dest;
      logic [15:0] version;
      logic [31:0] argument;
      logic [7:0]  flags;
      logic [31:0] crc_total;
      logic [31:0] good_total;
   } frame_report_type;

   // Ways the receiving side throttles the result channel.
   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_COIN,
      FLOW_SPARSE,
      FLOW_PERIODIC
   } rsp_flow_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_frame_status;
   logic [7:0]  rsp_frame_type;
   logic [15:0] rsp_source_tag;
   logic [15:0] rsp_dest_tag;
   logic [15:0] rsp_proto_version;
   logic [31:0] rsp_argument;
   logic [7:0]  rsp_frame_flags;
   logic [31:0] rsp_crc_error_total;
   logic [31:0] rsp_good_frame_total;

   sync_frame_deframer_crc16 u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_frame_status     (rsp_frame_status),
      .rsp_frame_type       (rsp_frame_type),
      .rsp_source_tag       (rsp_source_tag),
      .rsp_dest_tag         (rsp_dest_tag),
      .rsp_proto_version    (rsp_proto_version),
      .rsp_argument         (rsp_argument),
      .rsp_frame_flags      (rsp_frame_flags),
      .rsp_crc_error_total  (rsp_crc_error_total),
      .rsp_good_frame_total (rsp_good_frame_total)
   );

   always #5 clock = ~clock;

   // Line bytes waiting to be offered, and reports the deframer still owes us.
   logic [7:0]       line_bytes [$];
   frame_report_type pending_reports [$];

   // Our own picture of the deframer state. The tag is only changed while the
   // block is idle, so the predictor always sees the value the block uses.
   logic [15:0]      node_tag = '0;
   logic [3:0]       hunt_pos = '0;
   frame_image_type  frame_buf = '0;
   logic [31:0]      crc_fail_count = '0;
   logic [31:0]      good_count = '0;

   int status_tally [3] = '{0, 0, 0};
   int bytes_accepted = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int tag_settings = 1;
   int cycle_count = 0;

   logic hold_request = 1'b0;

   // CRC-16/CCITT-FALSE worked one bit at a time: the feedback bit is the
   // top of the register xored with the incoming data bit, MSB first.
   function automatic logic [15:0] crc16_over(input frame_image_type img, input int n);
      logic [15:0] acc;
      logic        fb;
      acc = sfd_pkg::CRC_INIT;
      for (int i = 0; i < n; i++) begin
         for (int k = 7; k >= 0; k--) begin
            fb  = acc[15] ^ img[i][k];
            acc = {acc[14:0], 1'b0} ^ (fb ? sfd_pkg::CRC_POLY : 16'h0000);
         end
      end
      return acc;
   endfunction

   // Feeds one accepted line byte through the predictor. A byte that closes a
   // frame queues the report the block has to give for it.
   task automatic absorb_line_byte(input logic [7:0] b);
      frame_report_type rep;
      logic [15:0]      crc_sent;
      if (hunt_pos == 0 && b != sfd_pkg::SYNC_BYTE) begin
         return;
      end
      frame_buf[hunt_pos] = b;
      if (hunt_pos != 4'(sfd_pkg::FRAME_BYTES - 1)) begin
         hunt_pos++;
         return;
      end
      hunt_pos = '0;
      rep = '0;
      crc_sent = {frame_buf[sfd_pkg::FRAME_BYTES-1], frame_buf[sfd_pkg::FRAME_BYTES-2]};
      if (crc_sent != crc16_over(frame_buf, sfd_pkg::FRAME_BYTES - 2)) begin
         // A failed frame keeps all decoded fields at zero.
         crc_fail_count++;
         rep.status = sfd_pkg::STATUS_CRC;
      end else begin
         rep.ftype    = frame_buf[1];
         rep.source   = {frame_buf[3], frame_buf[2]};
         rep.dest     = {frame_buf[5], frame_buf[4]};
         rep.version  = {frame_buf[7], frame_buf[6]};
         rep.argument = {frame_buf[11], frame_buf[10], frame_buf[9], frame_buf[8]};
         rep.flags    = frame_buf[12];
         if (rep.source == node_tag) begin
            rep.status = sfd_pkg::STATUS_OWN;
         end else begin
            good_count++;
            rep.status = sfd_pkg::STATUS_GOOD;
         end
      end
      rep.crc_total  = crc_fail_count;
      rep.good_total = good_count;
      status_tally[rep.status]++;
      pending_reports.push_back(rep);
   endtask

   // Builds a frame with a correct CRC and queues its bytes. When damaged, one
   // byte after the sync byte gets a nonzero bit pattern flipped, which a
   // 16-bit CRC always catches.
   task automatic push_frame(input logic [7:0] ftype, input logic [15:0] src,
                             input logic [15:0] dst, input logic [15:0] ver,
                             input logic [31:0] arg, input logic [7:0] flags,
                             input bit damaged);
      frame_image_type img;
      logic [15:0]     crc;
      int              spot;
      img     = '0;
      img[0]  = sfd_pkg::SYNC_BYTE;
      img[1]  = ftype;
      img[2]  = src[7:0];
      img[3]  = src[15:8];
      img[4]  = dst[7:0];
      img[5]  = dst[15:8];
      img[6]  = ver[7:0];
      img[7]  = ver[15:8];
      img[8]  = arg[7:0];
      img[9]  = arg[15:8];
      img[10] = arg[23:16];
      img[11] = arg[31:24];
      img[12] = flags;
      img[13] = 8'($urandom);
      crc = crc16_over(img, sfd_pkg::FRAME_BYTES - 2);
      img[14] = crc[7:0];
      img[15] = crc[15:8];
      if (damaged) begin
         spot = $urandom_range(1, sfd_pkg::FRAME_BYTES - 1);
         img[spot] = img[spot] ^ 8'($urandom_range(1, 255));
      end
      for (int i = 0; i < sfd_pkg::FRAME_BYTES; i++) begin
         line_bytes.push_back(img[i]);
      end
   endtask

   // Line noise. The sync byte shows up only rarely, since a stray sync
   // throws the hunt out of step with the frames that follow.
   function automatic logic [7:0] stray_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == sfd_pkg::SYNC_BYTE && $urandom_range(0, 19) != 0) begin
         b = ~b;
      end
      return b;
   endfunction

   // Tag-like fields lean toward their extremes.
   function automatic logic [15:0] pick_tag();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_random_frame();
      int          roll;
      int          cut;
      logic [15:0] src;
      logic [31:0] arg;
      roll = $urandom_range(0, 9);
      src  = (roll < 2) ? node_tag : pick_tag();
      case ($urandom_range(0, 4))
         0:       arg = 32'h0000_0000;
         1:       arg = 32'hFFFF_FFFF;
         default: arg = $urandom;
      endcase
      push_frame(8'($urandom), src, pick_tag(), pick_tag(), arg, 8'($urandom), roll == 8);
      if (roll == 9) begin
         // Broken frame: the tail is replaced by line noise of the same length.
         cut = $urandom_range(1, sfd_pkg::FRAME_BYTES - 1);
         repeat (cut) void'(line_bytes.pop_back());
         repeat (cut) line_bytes.push_back(stray_byte());
      end
      if ($urandom_range(0, 1) != 0) begin
         repeat ($urandom_range(1, 3)) line_bytes.push_back(stray_byte());
      end
   endtask

   // Waits until every queued byte has gone in and every report has come out,
   // then gives the block a settle period for a frame still in its pipeline.
   task automatic drain_and_settle();
      do begin
         @(negedge clock);
      end while (line_bytes.size() != 0 || req_valid || pending_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_own_tag(input logic [15:0] tag);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= tag;
      node_tag     = tag;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         flag_error($sformatf("result %0d, %s: expected %h, got %h",
                              results_seen, name, want, got));
      end
   endtask

   // Byte driver. It offers queued line bytes in bursts of random length with
   // random gaps in between; a stalled transaction keeps its byte untouched.
   // The predictor is fed at the very edge where a transaction is accepted.
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_line_byte(req_rx_byte);
            bytes_accepted++;
         end
         if (req_valid && req_stall) begin
            // Hold the offered byte until the block takes it.
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (line_bytes.size() != 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= line_bytes.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               // About a third of the bursts run straight into the next one.
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver. It switches between throttling styles at random intervals,
   // and once in the run it stalls for a long stretch so that the frame queue
   // fills and the byte input has to stall too.
   rsp_flow_type flow_style = FLOW_FREE;
   int           flow_left = 0;
   int           hold_left = 0;
   bit           hold_started = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = LONG_HOLD_CYCLES;
         end
         if (flow_left == 0) begin
            flow_style = rsp_flow_type'($urandom_range(0, 3));
            flow_left  = $urandom_range(8, 64);
         end
         flow_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (flow_style)
               FLOW_FREE:   rsp_stall <= 1'b0;
               FLOW_COIN:   rsp_stall <= ($urandom_range(0, 1) != 0);
               FLOW_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:     rsp_stall <= ((flow_left % 3) != 0);
            endcase
         end
      end
   end

   // Result monitor: every accepted transaction is checked field by field
   // against the oldest report still owed.
   always @(posedge clock) begin
      frame_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_reports.size() == 0) begin
            flag_error($sformatf("result %0d arrived with no frame completed for it",
                                 results_seen));
         end else begin
            want = pending_reports.pop_front();
            compare_field("frame_status", want.status, rsp_frame_status);
            compare_field("frame_type", want.ftype, rsp_frame_type);
            compare_field("source_tag", want.source, rsp_source_tag);
            compare_field("dest_tag", want.dest, rsp_dest_tag);
            compare_field("proto_version", want.version, rsp_proto_version);
            compare_field("argument", want.argument, rsp_argument);
            compare_field("frame_flags", want.flags, rsp_frame_flags);
            compare_field("crc_error_total", want.crc_total, rsp_crc_error_total);
            compare_field("good_frame_total", want.good_total, rsp_good_frame_total);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the reset tag of zero: noise at both byte extremes,
      // an own frame with every field zero, a frame with a CRC mismatch, and a
      // foreign frame with every field at its maximum.
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      push_frame(8'h00, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00, 1'b0);
      push_frame(8'h3C, 16'h1234, 16'h5678, 16'h0001, 32'h89AB_CDEF, 8'h81, 1'b1);
      push_frame(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
      drain_and_settle();

      // With the tag at its maximum the all-ones frame becomes our own, and a
      // broadcast frame from tag zero is a foreign one.
      write_own_tag(16'hFFFF);
      tag_settings++;
      @(negedge clock);
      push_frame(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
      push_frame(8'h5A, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00, 1'b0);
      drain_and_settle();

      // Random part: mostly well-formed frames with random content, mixed with
      // own frames, damaged frames, broken frames and line noise. The tag moves
      // between random values and its extremes from phase to phase.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       write_own_tag(16'h0000);
            3:       write_own_tag(16'hFFFF);
            default: write_own_tag(16'($urandom));
         endcase
         tag_settings++;
         @(negedge clock);
         if (phase == 0) begin
            hold_request = 1'b1;
         end
         repeat (FRAMES_PER_PHASE) push_random_frame();
         drain_and_settle();
      end

      $display("Line bytes taken: %0d; frames closed: %0d good, %0d CRC-failed, %0d own.",
               bytes_accepted, status_tally[sfd_pkg::STATUS_GOOD],
               status_tally[sfd_pkg::STATUS_CRC], status_tally[sfd_pkg::STATUS_OWN]);
      $display("Own tag written %0d times; %0d result transactions checked, %0d mismatches.",
               tag_settings - 1, results_seen, mismatch_count);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sync_frame_deframer_crc16.f
rtl/sfd_pkg.sv
rtl/sfd_front.sv
rtl/sfd_queue.sv
rtl/sfd_back.sv
rtl/sync_frame_deframer_crc16.sv
tb/testbench.sv
